// ===== rtl/decimal_scale_aligner_core_defines.svh =====
// ----------------------------------------------------------------------------
// Decimal scale aligner assertion macros
// Shared concurrent assertion wrappers for the decimal scale aligner RTL.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_SCALE_ALIGNER_CORE_DEFINES_SVH
`define DECIMAL_SCALE_ALIGNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal scale aligner package
// Item types and arithmetic constants of the decimal scale aligner.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned LowBits        = 64;
  localparam int unsigned HighBits       = 32;
  localparam int unsigned MagIoBits      = LowBits + HighBits;
  localparam int unsigned ScaleBits      = 5;
  localparam int unsigned DefaultMagBits = 96;

  // The divide-by-ten unit handles one chunk of the dividend per cycle.
  localparam int unsigned ChunkBits = 16;
  localparam int unsigned RemBits   = 4;
  localparam int unsigned DigitBits = ChunkBits + RemBits;
  // Reciprocal of ten scaled by 2**23, rounded up; exact for any 20-bit value.
  localparam int unsigned RecipBits = 20;
  localparam int unsigned DivShift  = 23;
  localparam int unsigned ProdBits  = DigitBits + RecipBits;
  localparam logic [RecipBits-1:0] DivRecip = RecipBits'(838861);
  localparam logic [RemBits-1:0]   RemMax   = RemBits'(9);
  localparam logic [RemBits-1:0]   RemHalf  = RemBits'(5);

  typedef struct packed {
    logic [LowBits-1:0]   a_mag_low;
    logic [HighBits-1:0]  a_mag_high;
    logic [ScaleBits-1:0] a_scale;
    logic                 a_negative;
    logic [LowBits-1:0]   b_mag_low;
    logic [HighBits-1:0]  b_mag_high;
    logic [ScaleBits-1:0] b_scale;
    logic                 b_negative;
  } dsa_in_t;

  typedef struct packed {
    logic [LowBits-1:0]   a_out_low;
    logic [HighBits-1:0]  a_out_high;
    logic [ScaleBits-1:0] a_out_scale;
    logic                 a_out_negative;
    logic [LowBits-1:0]   b_out_low;
    logic [HighBits-1:0]  b_out_high;
    logic [ScaleBits-1:0] b_out_scale;
    logic                 b_out_negative;
  } dsa_out_t;

endpackage

// ===== rtl/decimal_scale_aligner_core.sv =====
// ----------------------------------------------------------------------------
// Decimal scale aligner core
// Brings two signed decimal numbers (magnitude, scale, sign) to one scale.
// ----------------------------------------------------------------------------
// Usage: an input item carries two numbers, each a 96-bit magnitude split in
// a low and a high word, a power-of-ten scale and a sign. It is accepted when
// in_valid_i is high and in_stall_o is low. The result item leaves on the
// out channel and is taken when out_valid_o is high and out_stall_i is low.
// The block handles one item at a time and holds in_stall_o high while busy.
// After acceptance the sequencer takes M multiply-by-ten steps and D
// divide-by-ten steps, where M + D is the scale difference, at most 31.
// A multiply step is done in the decide state; a divide step passes through
// the decide, divide and round states. NumChunks is MAG_BITS / 16 rounded
// up, 6 at the default width; the divide unit consumes one 16-bit chunk per
// cycle. With equal scales the item goes straight from decide to finish.
// The next item is accepted once the sequencer is back in the idle state.
// The result sits in an output register, so a new item may be taken while a
// finished result still waits on a stalled receiver; the block stalls only
// when it is ready to hand over a second result. Reset clears the sequencer
// and the output valid flag; no item is in flight afterwards.
// ----------------------------------------------------------------------------
`include "decimal_scale_aligner_core_defines.svh"

module decimal_scale_aligner_core
  import dsa_pkg::*;
#(
  parameter int unsigned MAG_BITS = DefaultMagBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dsa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dsa_out_t out_data_o
);

  // Width used when moving magnitudes between the port and internal widths.
  localparam int unsigned WideBits  = (MAG_BITS > MagIoBits) ? MAG_BITS : MagIoBits;
  localparam int unsigned NumChunks = (MAG_BITS + ChunkBits - 1) / ChunkBits;
  localparam int unsigned PadBits   = NumChunks * ChunkBits;
  localparam int unsigned CntBits   = (NumChunks > 1) ? $clog2(NumChunks) : 1;
  // Largest magnitude that can still be multiplied by ten without overflow.
  localparam logic [MAG_BITS-1:0] MagLim = {MAG_BITS{1'b1}} / MAG_BITS'(10);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_ROUND,
    ST_FINISH
  } state_e;

  function automatic logic [MAG_BITS-1:0] to_mag(input logic [MagIoBits-1:0] v);
    logic [WideBits-1:0] w;
    w = WideBits'(v);
    return w[MAG_BITS-1:0];
  endfunction

  function automatic logic [MagIoBits-1:0] to_io(input logic [MAG_BITS-1:0] v);
    logic [WideBits-1:0] w;
    w = WideBits'(v);
    return w[MagIoBits-1:0];
  endfunction

  state_e                state_q, state_d;
  logic [MAG_BITS-1:0]   a_mag_q, a_mag_d, b_mag_q, b_mag_d;
  logic [ScaleBits-1:0]  a_scale_q, a_scale_d, b_scale_q, b_scale_d;
  logic                  a_neg_q, a_neg_d, b_neg_q, b_neg_d;
  logic                  big_is_b_q, big_is_b_d;
  logic [ScaleBits-1:0]  step_q, step_d;
  logic [PadBits-1:0]    div_q, div_d;
  logic [RemBits-1:0]    rem_q, rem_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  dsa_out_t              out_q, out_d;

  logic [MAG_BITS-1:0]   small_mag, big_mag, mul_mag, quo_mag;
  logic [ScaleBits-1:0]  small_scale, big_scale;
  logic [DigitBits-1:0]  digit_v, digit_ten;
  logic [ProdBits-1:0]   digit_prod;
  logic [ChunkBits-1:0]  digit_q;
  logic [RemBits-1:0]    digit_r;
  logic                  round_up;
  logic                  out_free;

  // Operand selection: the number with the larger scale is the divide target.
  assign small_mag   = big_is_b_q ? a_mag_q : b_mag_q;
  assign big_mag     = big_is_b_q ? b_mag_q : a_mag_q;
  assign small_scale = big_is_b_q ? a_scale_q : b_scale_q;
  assign big_scale   = big_is_b_q ? b_scale_q : a_scale_q;

  // Multiply by ten as 8x + 2x; only used when the result is known to fit.
  assign mul_mag = (small_mag << 3) + (small_mag << 1);

  // One long-division digit step: the running remainder and the next chunk
  // form a 20-bit value that is divided by ten through its reciprocal.
  assign digit_v    = {rem_q, div_q[PadBits-1 -: ChunkBits]};
  assign digit_prod = ProdBits'(digit_v) * ProdBits'(DivRecip);
  assign digit_q    = digit_prod[DivShift +: ChunkBits];
  assign digit_ten  = (DigitBits'(digit_q) << 3) + (DigitBits'(digit_q) << 1);
  assign digit_r    = RemBits'(digit_v - digit_ten);

  // Only the division in the final step rounds, half to even.
  assign round_up = (step_q == ScaleBits'(1)) &&
                    ((rem_q > RemHalf) || ((rem_q == RemHalf) && div_q[0]));
  assign quo_mag  = div_q[MAG_BITS-1:0] + MAG_BITS'(round_up);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    a_mag_d     = a_mag_q;
    b_mag_d     = b_mag_q;
    a_scale_d   = a_scale_q;
    b_scale_d   = b_scale_q;
    a_neg_d     = a_neg_q;
    b_neg_d     = b_neg_q;
    big_is_b_d  = big_is_b_q;
    step_d      = step_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          a_mag_d    = to_mag({in_data_i.a_mag_high, in_data_i.a_mag_low});
          b_mag_d    = to_mag({in_data_i.b_mag_high, in_data_i.b_mag_low});
          a_scale_d  = in_data_i.a_scale;
          b_scale_d  = in_data_i.b_scale;
          a_neg_d    = in_data_i.a_negative;
          b_neg_d    = in_data_i.b_negative;
          big_is_b_d = !(in_data_i.a_scale > in_data_i.b_scale);
          step_d     = big_is_b_d ? (in_data_i.b_scale - in_data_i.a_scale)
                                  : (in_data_i.a_scale - in_data_i.b_scale);
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (step_q == '0) begin
          state_d = ST_FINISH;
        end else if (small_mag <= MagLim) begin
          if (big_is_b_q) begin
            a_mag_d   = mul_mag;
            a_scale_d = a_scale_q + ScaleBits'(1);
          end else begin
            b_mag_d   = mul_mag;
            b_scale_d = b_scale_q + ScaleBits'(1);
          end
          step_d = step_q - ScaleBits'(1);
        end else begin
          div_d   = PadBits'(big_mag);
          rem_d   = '0;
          cnt_d   = CntBits'(NumChunks - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        div_d = {div_q[PadBits-ChunkBits-1:0], digit_q};
        rem_d = digit_r;
        cnt_d = cnt_q - CntBits'(1);
        if (cnt_q == '0) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (big_is_b_q) begin
          b_mag_d   = quo_mag;
          b_scale_d = b_scale_q - ScaleBits'(1);
        end else begin
          a_mag_d   = quo_mag;
          a_scale_d = a_scale_q - ScaleBits'(1);
        end
        step_d  = step_q - ScaleBits'(1);
        state_d = ST_DECIDE;
      end
      ST_FINISH: begin
        if (out_free) begin
          {out_d.a_out_high, out_d.a_out_low} = to_io(a_mag_q);
          {out_d.b_out_high, out_d.b_out_low} = to_io(b_mag_q);
          out_d.a_out_scale    = a_scale_q;
          out_d.b_out_scale    = b_scale_q;
          out_d.a_out_negative = a_neg_q;
          out_d.b_out_negative = b_neg_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      cnt_q       <= '0;
      big_is_b_q  <= 1'b0;
      a_mag_q     <= '0;
      b_mag_q     <= '0;
      a_scale_q   <= '0;
      b_scale_q   <= '0;
      a_neg_q     <= 1'b0;
      b_neg_q     <= 1'b0;
      div_q       <= '0;
      rem_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      big_is_b_q  <= big_is_b_d;
      a_mag_q     <= a_mag_d;
      b_mag_q     <= b_mag_d;
      a_scale_q   <= a_scale_d;
      b_scale_q   <= b_scale_d;
      a_neg_q     <= a_neg_d;
      b_neg_q     <= b_neg_d;
      div_q       <= div_d;
      rem_q       <= rem_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The scale gap always equals the number of steps still to do.
  `DSA_ASSERT_SAME(a_scale_gap, clk_i, rst_ni, state_q != ST_IDLE, (big_scale - small_scale) == step_q, "scale gap and step count disagree")
  // A running division keeps a decimal remainder and has a step to finish.
  `DSA_ASSERT_SAME(a_div_rem, clk_i, rst_ni, state_q == ST_DIV, (rem_q <= RemMax) && (step_q != '0), "divide unit out of range")
  // An accepted item starts the sequencer on the next cycle.
  `DSA_ASSERT_NEXT(a_start, clk_i, rst_ni, (state_q == ST_IDLE) && in_valid_i, state_q == ST_DECIDE, "item accepted but sequencer idle")
  // A finished item lands in the output register and frees the input.
  `DSA_ASSERT_NEXT(a_finish, clk_i, rst_ni, (state_q == ST_FINISH) && out_free, out_valid_q && (state_q == ST_IDLE), "finished item not delivered")

endmodule
